FILE: rtl/core/rgsc_pkg.sv
// shared types and constants of the replay guard with sequence cache
`timescale 1ns / 1ps

package rgsc_pkg;

    localparam int CACHE_DEPTH   = 8;
    localparam int MAX_REPLY_LEN = 256;

    localparam int SEQ_W   = 32;
    localparam int FP_W    = 16;
    localparam int RLEN_W  = 16;
    localparam int SLOT_W  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int DEP_W   = $clog2(CACHE_DEPTH + 1);
    localparam int LEN_W   = $clog2(MAX_REPLY_LEN + 1);
    localparam int CFG_W   = 8;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    // register indexes
    localparam int REG_RING_DEPTH = 0;

    typedef enum logic [0:0] {
        CMD_CHECK  = 1'b0,
        CMD_COMMIT = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        V_FRESH  = 2'd0,
        V_STALE  = 2'd1,
        V_CACHED = 2'd2,
        V_COMMIT = 2'd3
    } t_verdict;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic [FP_W-1:0]   fp;
        logic [LEN_W-1:0]  len;
    } t_ring_wr;

    typedef struct packed {
        logic             used;
        logic [SEQ_W-1:0] seq;
        logic [FP_W-1:0]  fp;
        logic [LEN_W-1:0] len;
    } t_ring_rd;

    typedef struct packed {
        logic [SEQ_W-1:0] diff;
        logic             zero;
        logic             neg;
    } t_sub_res;

endpackage

FILE: rtl/core/rgsc_sub_unit.sv
// shared 32-bit subtract and compare unit
`timescale 1ns / 1ps

module rgsc_sub_unit
    import rgsc_pkg::*;
(
    input  logic [SEQ_W-1:0] i_a,
    input  logic [SEQ_W-1:0] i_b,
    output t_sub_res         o_res
);

    logic [SEQ_W-1:0] diff;

    assign diff       = i_a - i_b;
    assign o_res.diff = diff;
    assign o_res.zero = (diff == '0);
    assign o_res.neg  = diff[SEQ_W-1];

endmodule

FILE: rtl/core/rgsc_ring.sv
// ring of cached entries with used bits and registered read port
`timescale 1ns / 1ps

module rgsc_ring
    import rgsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ring_wr          i_wr,
    input  logic              i_rd_en,
    input  logic [SLOT_W-1:0] i_rd_addr,
    output t_ring_rd          o_rd
);

    logic [CACHE_DEPTH-1:0] r_used;
    logic [SEQ_W-1:0]       r_seq_mem [CACHE_DEPTH];
    logic [FP_W-1:0]        r_fp_mem  [CACHE_DEPTH];
    logic [LEN_W-1:0]       r_len_mem [CACHE_DEPTH];
    logic                   r_rd_used;
    logic [SEQ_W-1:0]       r_rd_seq;
    logic [FP_W-1:0]        r_rd_fp;
    logic [LEN_W-1:0]       r_rd_len;

    // used bits are cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_used <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_used[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_used <= r_used[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_seq_mem[i_wr.addr] <= i_wr.seq;
            r_fp_mem[i_wr.addr]  <= i_wr.fp;
            r_len_mem[i_wr.addr] <= i_wr.len;
        end
        if (i_rd_en) begin
            r_rd_seq <= r_seq_mem[i_rd_addr];
            r_rd_fp  <= r_fp_mem[i_rd_addr];
            r_rd_len <= r_len_mem[i_rd_addr];
        end
    end

    assign o_rd.used = r_rd_used;
    assign o_rd.seq  = r_rd_seq;
    assign o_rd.fp   = r_rd_fp;
    assign o_rd.len  = r_rd_len;

endmodule

FILE: rtl/core/replay_guard_seq_cache.sv
// top level of the anti-replay guard: sequencer, config register, output register
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ---------------------------------------
//  request   in         i_valid / o_ready     i_cmd, i_seq, i_payload_fp, i_reply_len
//  result    out        o_valid / i_ready     o_verdict, o_slot, o_reply_length
//  config    in         psel/penable/pready   paddr, pwrite, pwdata, prdata
//
//  a check that comes out fresh goes from accept through the fresh and done states to o_valid
//  a stale or cached check walks the ring one slot per cycle, up to the active ring depth
//  a commit passes the fresh state, then the subtract steps of the slot wrap, then the done state
//  one shared subtractor does the sequence compare, the slot matching and the wrap
//  reset is synchronous, active low, and leaves the ring empty with no clearing pass
//  a transaction is taken again as soon as the result sits in the output register
`timescale 1ns / 1ps

module replay_guard_seq_cache
    import rgsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic [SEQ_W-1:0]   i_seq,
    input  logic [FP_W-1:0]    i_payload_fp,
    input  logic [RLEN_W-1:0]  i_reply_len,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_verdict,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [LEN_W-1:0]   o_reply_length,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRESH,
        S_SCAN,
        S_MOD,
        S_DONE
    } t_state;

    t_state            r_state;

    // latched transaction
    t_cmd              r_cmd;
    logic [SEQ_W-1:0]  r_seq;
    logic [FP_W-1:0]   r_fp;
    logic [LEN_W-1:0]  r_len;

    // guard state
    logic [CFG_W-1:0]  r_ring_depth;
    logic [SEQ_W-1:0]  r_last_seq;
    logic              r_seen_any;
    logic [SLOT_W-1:0] r_next_slot;

    // scan and wrap bookkeeping
    logic [DEP_W-1:0]  r_idx;
    logic              r_pend;
    logic [SLOT_W-1:0] r_pidx;
    logic [DEP_W-1:0]  r_mod;

    // pending result
    t_verdict          r_res_verdict;
    logic [SLOT_W-1:0] r_res_slot;
    logic [LEN_W-1:0]  r_res_len;

    // output register
    logic              r_out_valid;
    t_verdict          r_out_verdict;
    logic [SLOT_W-1:0] r_out_slot;
    logic [LEN_W-1:0]  r_out_len;

    logic [DEP_W-1:0]  eff_depth;
    logic [SEQ_W-1:0]  sub_a;
    logic [SEQ_W-1:0]  sub_b;
    t_sub_res          sub_res;
    logic              is_fresh;
    logic              scan_issue;
    logic              scan_hit;
    logic              out_free;
    logic              cfg_wr;
    logic [LEN_W-1:0]  clamped_len;
    t_ring_wr          ring_wr;
    t_ring_rd          ring_rd;

    // 0, or anything above the ring size, selects the full ring
    assign eff_depth = (r_ring_depth == '0 || r_ring_depth > CFG_W'(CACHE_DEPTH))
                       ? DEP_W'(CACHE_DEPTH) : r_ring_depth[DEP_W-1:0];

    // saturate the reply length on the way in
    assign clamped_len = (i_reply_len > RLEN_W'(MAX_REPLY_LEN))
                         ? LEN_W'(MAX_REPLY_LEN) : i_reply_len[LEN_W-1:0];

    // operand select for the shared subtractor
    always_comb begin
        unique case (r_state)
            S_SCAN: begin
                sub_a = r_seq;
                sub_b = ring_rd.seq;
            end
            S_MOD: begin
                sub_a = SEQ_W'(r_mod);
                sub_b = SEQ_W'(eff_depth);
            end
            default: begin
                sub_a = r_seq;
                sub_b = r_last_seq;
            end
        endcase
    end

    rgsc_sub_unit u_sub (
        .i_a   (sub_a),
        .i_b   (sub_b),
        .o_res (sub_res)
    );

    // newer means a positive, non-zero wrapping difference
    assign is_fresh = !r_seen_any || (!sub_res.zero && !sub_res.neg);

    // scan: issue slot r_idx while the slot whose data just came back is compared
    assign scan_issue = (r_state == S_SCAN) && (r_idx < eff_depth);
    assign scan_hit   = r_pend && ring_rd.used && sub_res.zero;

    // commit writes the ring while the freshness compare runs
    assign ring_wr.en   = (r_state == S_FRESH) && (r_cmd == CMD_COMMIT);
    assign ring_wr.addr = r_next_slot;
    assign ring_wr.seq  = r_seq;
    assign ring_wr.fp   = r_fp;
    assign ring_wr.len  = r_len;

    rgsc_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (ring_wr),
        .i_rd_en   (scan_issue),
        .i_rd_addr (r_idx[SLOT_W-1:0]),
        .o_rd      (ring_rd)
    );

    assign out_free = !r_out_valid || i_ready;

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_seq  <= '0;
            r_seen_any  <= 1'b0;
            r_next_slot <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // the done state reloads the output register itself
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= t_cmd'(i_cmd);
                        r_seq   <= i_seq;
                        r_fp    <= i_payload_fp;
                        r_len   <= clamped_len;
                        r_state <= S_FRESH;
                    end
                end
                S_FRESH: begin
                    if (r_cmd == CMD_COMMIT) begin
                        r_res_verdict <= V_COMMIT;
                        r_res_slot    <= r_next_slot;
                        r_res_len     <= r_len;
                        if (is_fresh) begin
                            r_last_seq <= r_seq;
                            r_seen_any <= 1'b1;
                        end
                        r_mod   <= DEP_W'(r_next_slot) + DEP_W'(1);
                        r_state <= S_MOD;
                    end else if (is_fresh) begin
                        r_res_verdict <= V_FRESH;
                        r_res_slot    <= '0;
                        r_res_len     <= '0;
                        r_state       <= S_DONE;
                    end else begin
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend <= scan_issue;
                    r_pidx <= r_idx[SLOT_W-1:0];
                    r_idx  <= r_idx + DEP_W'(1);
                    if (scan_hit) begin
                        // first matching sequence decides, even on a fingerprint miss
                        if (ring_rd.fp == r_fp) begin
                            r_res_verdict <= V_CACHED;
                            r_res_slot    <= r_pidx;
                            r_res_len     <= ring_rd.len;
                        end else begin
                            r_res_verdict <= V_STALE;
                            r_res_slot    <= '0;
                            r_res_len     <= '0;
                        end
                        r_state <= S_DONE;
                    end else if (!scan_issue) begin
                        r_res_verdict <= V_STALE;
                        r_res_slot    <= '0;
                        r_res_len     <= '0;
                        r_state       <= S_DONE;
                    end
                end
                S_MOD: begin
                    // wrap by repeated subtraction of the ring depth
                    if (!sub_res.neg) begin
                        r_mod <= sub_res.diff[DEP_W-1:0];
                    end else begin
                        r_next_slot <= r_mod[SLOT_W-1:0];
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_verdict <= r_res_verdict;
                        r_out_slot    <= r_res_slot;
                        r_out_len     <= r_res_len;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_verdict      = r_out_verdict;
    assign o_slot         = r_out_slot;
    assign o_reply_length = r_out_len;

    // config register, one write per access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_RING_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_depth <= '0;
        end else if (cfg_wr) begin
            r_ring_depth <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_RING_DEPTH))
                    ? PDATA_W'(r_ring_depth) : '0;

`ifndef NO_ASSERTIONS
    // the sequencer is busy in the cycle after it accepts a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while previous one still in flight");

    // fresh and stale results carry no slot and no length
    a_plain_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_verdict == V_FRESH || o_verdict == V_STALE))
        |-> (o_slot == '0 && o_reply_length == '0))
        else $error("fresh or stale result with nonzero slot or length");

    // a cache hit lies inside the active part of the ring
    a_hit_in_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict == V_CACHED) |-> (DEP_W'(o_slot) < eff_depth))
        else $error("cached slot outside the active ring depth");

    // a committed length never exceeds the saturation limit
    a_commit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict == V_COMMIT) |-> (o_reply_length <= LEN_W'(MAX_REPLY_LEN)))
        else $error("committed reply length above limit");
`endif

endmodule

FILE: verif/replay_guard_seq_cache_tb.sv
// self-checking testbench for the replay guard with sequence cache
`timescale 1ns / 1ps

module replay_guard_seq_cache_tb;
    import rgsc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 24;
    localparam int PHASE_ITEMS = 106;
    localparam int SETTLE      = 16;   // longest walk plus output register, with margin

    // one request transaction as the driver puts it on the pins
    typedef struct packed {
        t_cmd              cmd;
        logic [SEQ_W-1:0]  seq;
        logic [FP_W-1:0]   fp;
        logic [RLEN_W-1:0] rlen;
    } t_frame;

    // one result transaction
    typedef struct packed {
        t_verdict          verdict;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
    } t_guard_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_cmd;
    logic [SEQ_W-1:0]   i_seq;
    logic [FP_W-1:0]    i_payload_fp;
    logic [RLEN_W-1:0]  i_reply_len;
    logic               o_valid;
    logic               i_ready;
    logic [1:0]         o_verdict;
    logic [SLOT_W-1:0]  o_slot;
    logic [LEN_W-1:0]   o_reply_length;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    replay_guard_seq_cache i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_seq          (i_seq),
        .i_payload_fp   (i_payload_fp),
        .i_reply_len    (i_reply_len),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_verdict      (o_verdict),
        .o_slot         (o_slot),
        .o_reply_length (o_reply_length),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: a private copy of the guard and its register
    // ------------------------------------------------------------------
    logic [7:0]        gd_depth_reg;
    logic [SEQ_W-1:0]  gd_last_seq;
    bit                gd_seen_any;
    int                gd_next_slot;
    bit                gd_used [CACHE_DEPTH];
    logic [SEQ_W-1:0]  gd_seq  [CACHE_DEPTH];
    logic [FP_W-1:0]   gd_fp   [CACHE_DEPTH];
    logic [LEN_W-1:0]  gd_len  [CACHE_DEPTH];

    t_frame        frame_q[$];             // requests waiting for the driver
    t_guard_result expected_verdicts[$];   // predicted results in order
    t_frame        recent_commits[$];      // stimulus memory for replays

    int  errors;
    int  cycles;
    bit  req_taken;     // request transaction accepted at the last rising edge
    bit  steady;        // no idling on either side while set
    logic [SEQ_W-1:0] stim_base;

    // slots in use: zero or anything past the ring size means the whole ring
    function automatic int ring_span();
        if (gd_depth_reg == 8'd0 || gd_depth_reg > CACHE_DEPTH)
            return CACHE_DEPTH;
        return int'(gd_depth_reg);
    endfunction

    // newer means nothing seen yet, or a positive signed 32-bit distance
    function automatic bit seq_is_newer(logic [SEQ_W-1:0] s);
        logic [SEQ_W-1:0] d;
        d = s - gd_last_seq;
        return !gd_seen_any || (d != '0 && !d[SEQ_W-1]);
    endfunction

    // work out the result of one request and advance the private state
    function automatic t_guard_result guard_predict(t_frame f);
        t_guard_result     r;
        int                span;
        int                w;
        bit                hit;
        logic [LEN_W-1:0]  clamped;
        span = ring_span();
        r = '{verdict: V_FRESH, slot: '0, len: '0};
        if (f.cmd == CMD_CHECK) begin
            if (!seq_is_newer(f.seq)) begin
                r.verdict = V_STALE;
                hit = 1'b0;
                // lowest used slot with the same seq decides, fingerprint or not
                for (int i = 0; i < span; i++) begin
                    if (!hit && gd_used[i] && gd_seq[i] == f.seq) begin
                        hit = 1'b1;
                        if (gd_fp[i] == f.fp) begin
                            r.verdict = V_CACHED;
                            r.slot    = SLOT_W'(i);
                            r.len     = gd_len[i];
                        end
                    end
                end
            end
        end else begin
            w = gd_next_slot % CACHE_DEPTH;
            // saturate the reply length
            clamped = (f.rlen > MAX_REPLY_LEN) ? LEN_W'(MAX_REPLY_LEN) : LEN_W'(f.rlen);
            // a lowered depth still writes the old slot, then wraps
            gd_next_slot = (w + 1) % span;
            gd_used[w] = 1'b1;
            gd_seq[w]  = f.seq;
            gd_fp[w]   = f.fp;
            gd_len[w]  = clamped;
            // a commit that is not fresh leaves last seq alone
            if (seq_is_newer(f.seq)) begin
                gd_last_seq = f.seq;
                gd_seen_any = 1'b1;
            end
            r.verdict = V_COMMIT;
            r.slot    = SLOT_W'(w);
            r.len     = clamped;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (errors < 40)
            $display("[%0d] mismatch: %s", cycles, what);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // driver and result sink: inputs move on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // hold the current transaction until it is taken
            if (!i_valid || req_taken) begin
                if (frame_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    i_cmd        <= frame_q[0].cmd;
                    i_seq        <= frame_q[0].seq;
                    i_payload_fp <= frame_q[0].fp;
                    i_reply_len  <= frame_q[0].rlen;
                    i_valid      <= 1'b1;
                    void'(frame_q.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on request accept, compare on result accept
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_frame        seen;
        t_guard_result want;
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("replay_guard_seq_cache regression: fail");
            $finish;
        end
        if (i_rst_n) begin
            req_taken <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                seen = '{cmd: t_cmd'(i_cmd), seq: i_seq, fp: i_payload_fp,
                         rlen: i_reply_len};
                expected_verdicts.push_back(guard_predict(seen));
            end
            if (o_valid && i_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending, verdict %0d",
                                              o_verdict));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_verdict !== want.verdict)
                        report_mismatch($sformatf("verdict %0d, want %0d",
                                                  o_verdict, want.verdict));
                    if (o_slot !== want.slot)
                        report_mismatch($sformatf("slot %0d, want %0d", o_slot, want.slot));
                    if (o_reply_length !== want.len)
                        report_mismatch($sformatf("reply_length %0d, want %0d",
                                                  o_reply_length, want.len));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_frame(t_cmd c, logic [SEQ_W-1:0] s, logic [FP_W-1:0] fp,
                             logic [RLEN_W-1:0] rl);
        frame_q.push_back('{cmd: c, seq: s, fp: fp, rlen: rl});
    endtask

    // wait until the block has nothing in flight, then a little longer
    task automatic wait_quiet();
        forever begin
            @(posedge i_clk);
            #1;
            if (frame_q.size() == 0 && !i_valid && expected_verdicts.size() == 0)
                break;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write ring_depth over the config port, then read it back
    task automatic program_depth(logic [7:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PADDR_W'(4 * REG_RING_DEPTH);
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        gd_depth_reg = value;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== PDATA_W'(value))
            report_mismatch($sformatf("ring_depth reads %0h, wrote %0h", prdata, value));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly well-formed traffic: commits on a moving sequence, checks that
    // replay recent commits, plus corrupted replays and random noise
    function automatic t_frame random_frame();
        t_frame f;
        int     pick;
        f.fp   = FP_W'($urandom());
        f.rlen = ($urandom_range(3) == 0) ? RLEN_W'($urandom())
                                           : RLEN_W'($urandom_range(0, 300));
        if ($urandom_range(99) < 35) begin
            f.cmd = CMD_COMMIT;
            pick  = $urandom_range(9);
            if (pick < 6 || recent_commits.size() == 0) begin
                stim_base += SEQ_W'($urandom_range(1, 40));
                f.seq = stim_base;
            end else if (pick < 8) begin
                // commit again under an already used sequence number
                f.seq = recent_commits[$urandom_range(recent_commits.size() - 1)].seq;
            end else if (pick == 8) begin
                // just at or behind the current edge
                f.seq = stim_base - SEQ_W'($urandom_range(0, 3));
            end else begin
                // jump anywhere, wraparound included
                stim_base = SEQ_W'($urandom());
                f.seq = stim_base;
            end
            recent_commits.push_back(f);
            if (recent_commits.size() > 12)
                void'(recent_commits.pop_front());
        end else begin
            f.cmd = CMD_CHECK;
            pick  = $urandom_range(19);
            if (pick < 9 && recent_commits.size() > 0) begin
                // faithful replay
                f = recent_commits[$urandom_range(recent_commits.size() - 1)];
                f.cmd  = CMD_CHECK;
                f.rlen = RLEN_W'($urandom());
            end else if (pick < 11 && recent_commits.size() > 0) begin
                // recent sequence with a recent fingerprint, not necessarily its own, one bit flipped
                f.seq = recent_commits[$urandom_range(recent_commits.size() - 1)].seq;
                f.fp  = recent_commits[$urandom_range(recent_commits.size() - 1)].fp
                        ^ FP_W'(1 << $urandom_range(FP_W - 1));
            end else if (pick < 14) begin
                f.seq = stim_base + SEQ_W'($urandom_range(0, 3));
            end else if (pick < 16) begin
                // around half the sequence space away
                f.seq = stim_base + 32'h7FFF_FFFF + SEQ_W'($urandom_range(0, 2));
            end else begin
                f.seq = SEQ_W'($urandom());
            end
        end
        return f;
    endfunction

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] depth_plan [8];
        // first phase drops the depth below the pending ring slot
        depth_plan = '{8'd3, 8'd8, 8'd255, 8'd1, 8'd9, 8'd2, 8'd6, 8'd0};
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_cmd        = 1'b0;
        i_seq        = '0;
        i_payload_fp = '0;
        i_reply_len  = '0;
        i_ready      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        errors       = 0;
        cycles       = 0;
        req_taken    = 1'b0;
        steady       = 1'b0;
        stim_base    = 32'hFFFF_FF80;   // the first random phase crosses the wrap
        gd_depth_reg = '0;
        gd_last_seq  = '0;
        gd_seen_any  = 1'b0;
        gd_next_slot = 0;
        foreach (gd_used[i]) gd_used[i] = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        program_depth(8'd0);

        // nothing seen yet: any check is fresh
        add_frame(CMD_CHECK,  32'd0,          16'h0000, 16'h0000);
        add_frame(CMD_CHECK,  32'hFFFF_FFFF,  16'hFFFF, 16'hFFFF);
        // first commit sets the last sequence number
        add_frame(CMD_COMMIT, 32'd100,        16'hFFFF, 16'h0000);
        add_frame(CMD_CHECK,  32'd100,        16'hFFFF, 16'h0000);
        // same seq, other payload
        add_frame(CMD_CHECK,  32'd100,        16'h0000, 16'h0000);
        add_frame(CMD_CHECK,  32'd99,         16'hFFFF, 16'h0000);
        add_frame(CMD_CHECK,  32'd101,        16'hFFFF, 16'h0000);
        // exactly half the space ahead is not newer, one less is
        add_frame(CMD_CHECK,  32'h8000_0064,  16'h0000, 16'h0000);
        add_frame(CMD_CHECK,  32'h8000_0063,  16'h0000, 16'h0000);
        // stale commits still fill slots; lengths saturate
        add_frame(CMD_COMMIT, 32'd50,         16'h1234, 16'hFFFF);
        add_frame(CMD_COMMIT, 32'd50,         16'h4321, 16'd257);
        add_frame(CMD_CHECK,  32'd50,         16'h1234, 16'h0000);
        // first seq match decides even though a later slot matches fully
        add_frame(CMD_CHECK,  32'd50,         16'h4321, 16'h0000);
        // walk the sequence across the wrap
        add_frame(CMD_COMMIT, 32'h8000_0032,  16'hAAAA, 16'd256);
        add_frame(CMD_COMMIT, 32'hFFFF_FFFF,  16'h5555, 16'd255);
        add_frame(CMD_COMMIT, 32'd5,          16'h0001, 16'd1);
        add_frame(CMD_CHECK,  32'hFFFF_FFFF,  16'h5555, 16'h0000);
        add_frame(CMD_CHECK,  32'd6,          16'h0000, 16'h0000);
        add_frame(CMD_CHECK,  32'd5,          16'h0001, 16'h0000);
        // equal seq commit is not fresh
        add_frame(CMD_COMMIT, 32'd5,          16'h0002, 16'd300);
        add_frame(CMD_CHECK,  32'd5,          16'h0001, 16'h0000);

        // random phases, each under its own ring depth
        for (int p = 0; p < 8; p++) begin
            wait_quiet();
            program_depth(depth_plan[p]);
            steady = (p == 1);
            repeat (PHASE_ITEMS) frame_q.push_back(random_frame());
        end
        wait_quiet();

        if (errors == 0)
            $display("replay_guard_seq_cache regression: pass");
        else
            $display("replay_guard_seq_cache regression: fail");
        $finish;
    end

endmodule
